// File: hdl/kce_pkg.sv
// Shared types, widths and reset constants for the KNN centroid edge test.
// Used by the channel interfaces and by every module of the block.
package kce_pkg;

  localparam int COORD_W   = 24;
  localparam int SQ_W      = 2 * COORD_W;
  localparam int DIST_W    = 50;
  localparam int SCALE_W   = 10;
  localparam int EXCL_W    = 20;
  localparam int HALF_W    = 25;
  localparam int PROD_W    = SCALE_W + HALF_W;
  localparam int BOUND_W   = SCALE_W + DIST_W;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = DIST_W;
  localparam int LANES     = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_EDGE_SCALE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SELF_EXCLUSION = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_MIN    = 2'd2;

  localparam logic [SCALE_W-1:0] EDGE_SCALE_RST     = 10'd4;
  localparam logic [EXCL_W-1:0]  SELF_EXCLUSION_RST = 20'd1049;
  localparam logic [DIST_W-1:0]  INITIAL_MIN_RST    = 50'd10485760000;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIFF,
    S_SQUARE,
    S_ACCUM,
    S_DIV_START,
    S_DIV_WAIT,
    S_CDIFF,
    S_CSQUARE,
    S_CSUM,
    S_COMPARE
  } kce_state_t;

  typedef struct packed {
    logic idle;
    logic diff;
    logic square;
    logic accum;
    logic div_start;
    logic cdiff;
    logic csquare;
    logic csum;
    logic finish;
  } kce_cmd_t;

  typedef struct packed {
    logic in_valid;
    logic last;
    logic div_done;
    logic is_edge;
    logic out_blocked;
  } kce_status_t;

  function automatic logic [COORD_W-1:0] abs_diff(input logic signed [COORD_W-1:0] a,
                                                  input logic signed [COORD_W-1:0] b);
    logic signed [COORD_W:0] d;
    logic [COORD_W:0]        m;
    d = $signed({a[COORD_W-1], a}) - $signed({b[COORD_W-1], b});
    m = d[COORD_W] ? (~d + 1'b1) : d;
    return m[COORD_W-1:0];
  endfunction

endpackage

// File: hdl/kce_item_if.sv
// Input channel: a query point with one of its neighbours per beat.
// Depends on kce_pkg for the coordinate width.
interface kce_item_if import kce_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] query_x;
  logic signed [COORD_W-1:0] query_y;
  logic signed [COORD_W-1:0] query_z;
  logic signed [COORD_W-1:0] nbr_x;
  logic signed [COORD_W-1:0] nbr_y;
  logic signed [COORD_W-1:0] nbr_z;
  logic                      last_neighbour;

  modport source (output valid, query_x, query_y, query_z, nbr_x, nbr_y, nbr_z,
                  last_neighbour, input ready);
  modport sink (input valid, query_x, query_y, query_z, nbr_x, nbr_y, nbr_z,
                last_neighbour, output ready);
endinterface

// File: hdl/kce_edge_if.sv
// Output channel: one edge point per beat.
// Depends on kce_pkg for the coordinate width.
interface kce_edge_if import kce_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] edge_x;
  logic signed [COORD_W-1:0] edge_y;
  logic signed [COORD_W-1:0] edge_z;

  modport source (output valid, edge_x, edge_y, edge_z, input ready);
  modport sink (input valid, edge_x, edge_y, edge_z, output ready);
endinterface

// File: hdl/kce_cfg_if.sv
// Configuration write channel: register index and write data per beat.
// Depends on kce_pkg for the index and data widths.
interface kce_cfg_if import kce_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] reg_index;
  logic [CFG_DAT_W-1:0] wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink (input valid, reg_index, wdata, output ready);
endinterface

// File: hdl/kce_ctrl.sv
// Controller state machine sequencing the datapath one item at a time.
// Depends on kce_pkg for the state, command and status types.
module kce_ctrl import kce_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  kce_status_t status,
  output kce_cmd_t    cmd
);

  kce_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        cmd.idle = 1'b1;
        if (status.in_valid) state_next = S_DIFF;
      end
      S_DIFF: begin
        cmd.diff   = 1'b1;
        state_next = S_SQUARE;
      end
      S_SQUARE: begin
        cmd.square = 1'b1;
        state_next = S_ACCUM;
      end
      S_ACCUM: begin
        cmd.accum  = 1'b1;
        state_next = status.last ? S_DIV_START : S_IDLE;
      end
      S_DIV_START: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (status.div_done) state_next = S_CDIFF;
      end
      S_CDIFF: begin
        cmd.cdiff  = 1'b1;
        state_next = S_CSQUARE;
      end
      S_CSQUARE: begin
        cmd.csquare = 1'b1;
        state_next  = S_CSUM;
      end
      S_CSUM: begin
        cmd.csum   = 1'b1;
        state_next = S_COMPARE;
      end
      S_COMPARE: begin
        if (!(status.is_edge && status.out_blocked)) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// File: hdl/kce_divider.sv
// Three-lane restoring divider, one quotient bit per lane each cycle.
// Divides signed sums by an unsigned count, truncating toward zero. Uses kce_pkg.
module kce_divider import kce_pkg::*; #(
  parameter int SUM_W = 30,
  parameter int CNT_W = 6
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [CNT_W-1:0]          divisor,
  input  logic signed [SUM_W-1:0]   dividend [LANES],
  output logic                      done,
  output logic signed [COORD_W-1:0] quotient [LANES]
);

  localparam int STEP_W = (SUM_W > 1) ? $clog2(SUM_W) : 1;

  logic              busy;
  logic [STEP_W-1:0] step;
  logic [CNT_W-1:0]  dvs;
  logic              neg  [LANES];
  logic [SUM_W-1:0]  mag  [LANES];
  logic [CNT_W-1:0]  rem  [LANES];
  logic [CNT_W:0]    trial [LANES];
  logic              fits [LANES];
  logic [SUM_W-1:0]  signed_q [LANES];

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      trial[i]    = {rem[i], mag[i][SUM_W-1]};
      fits[i]     = trial[i] >= {1'b0, dvs};
      signed_q[i] = neg[i] ? (~mag[i] + 1'b1) : mag[i];
      quotient[i] = signed_q[i][COORD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == STEP_W'(SUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvs <= divisor;
      for (int i = 0; i < LANES; i++) begin
        neg[i] <= dividend[i][SUM_W-1];
        mag[i] <= dividend[i][SUM_W-1] ? (~dividend[i] + 1'b1) : dividend[i];
        rem[i] <= '0;
      end
    end else if (busy) begin
      for (int i = 0; i < LANES; i++) begin
        mag[i] <= {mag[i][SUM_W-2:0], fits[i]};
        rem[i] <= fits[i] ? CNT_W'(trial[i] - {1'b0, dvs}) : trial[i][CNT_W-1:0];
      end
    end
  end

endmodule

// File: hdl/kce_datapath.sv
// Datapath: configuration registers, distance squares, neighbour sums,
// least distance, centroid test and the output register. Uses kce_pkg and kce_divider.
module kce_datapath import kce_pkg::*; #(
  parameter int MAX_NEIGHBOURS = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  kce_cmd_t     cmd,
  output kce_status_t  status,
  kce_item_if.sink     items,
  kce_edge_if.source   results,
  kce_cfg_if.sink      cfg
);

  localparam int CNT_W = $clog2(MAX_NEIGHBOURS + 1);
  localparam int SUM_W = COORD_W + CNT_W;

  logic [SCALE_W-1:0] edge_scale;
  logic [EXCL_W-1:0]  self_exclusion;
  logic [DIST_W-1:0]  initial_min_dist;

  logic signed [COORD_W-1:0] q     [LANES];
  logic signed [COORD_W-1:0] n     [LANES];
  logic                      last;
  logic [COORD_W-1:0]        mag   [LANES];
  logic [SQ_W-1:0]           sq    [LANES];
  logic signed [SUM_W-1:0]   sum   [LANES];
  logic [CNT_W-1:0]          count;
  logic [DIST_W-1:0]         least;
  logic [PROD_W-1:0]         prod_lo;
  logic [PROD_W-1:0]         prod_hi;
  logic [DIST_W-1:0]         dist_c;
  logic [BOUND_W-1:0]        bound;
  logic                      out_valid;
  logic signed [COORD_W-1:0] out_q [LANES];

  logic                      accept;
  logic [DIST_W-1:0]         sq_sum;
  logic                      keep;
  logic                      div_done;
  logic signed [COORD_W-1:0] quot  [LANES];
  logic signed [COORD_W-1:0] cent  [LANES];

  assign accept      = cmd.idle & items.valid;
  assign items.ready = cmd.idle;
  assign cfg.ready   = 1'b1;

  assign sq_sum = DIST_W'(sq[0]) + DIST_W'(sq[1]) + DIST_W'(sq[2]);
  assign keep   = (sq_sum > DIST_W'(self_exclusion)) && (count < CNT_W'(MAX_NEIGHBOURS));

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      cent[i] = (count == '0) ? '0 : quot[i];
    end
  end

  assign status.in_valid    = items.valid;
  assign status.last        = last;
  assign status.div_done    = div_done;
  assign status.is_edge     = BOUND_W'(dist_c) > bound;
  assign status.out_blocked = out_valid & ~results.ready;

  assign results.valid  = out_valid;
  assign results.edge_x = out_q[0];
  assign results.edge_y = out_q[1];
  assign results.edge_z = out_q[2];

  kce_divider #(
    .SUM_W (SUM_W),
    .CNT_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .divisor  (count),
    .dividend (sum),
    .done     (div_done),
    .quotient (quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      edge_scale       <= EDGE_SCALE_RST;
      self_exclusion   <= SELF_EXCLUSION_RST;
      initial_min_dist <= INITIAL_MIN_RST;
    end else if (cfg.valid) begin
      case (cfg.reg_index)
        CFG_EDGE_SCALE:     edge_scale       <= cfg.wdata[SCALE_W-1:0];
        CFG_SELF_EXCLUSION: self_exclusion   <= cfg.wdata[EXCL_W-1:0];
        CFG_INITIAL_MIN:    initial_min_dist <= cfg.wdata[DIST_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LANES; i++) sum[i] <= '0;
      count     <= '0;
      least     <= INITIAL_MIN_RST;
      out_valid <= 1'b0;
    end else begin
      if (cmd.accum && keep) begin
        for (int i = 0; i < LANES; i++) sum[i] <= sum[i] + SUM_W'(n[i]);
        count <= count + 1'b1;
        if (sq_sum < least) least <= sq_sum;
      end
      if (cmd.finish) begin
        for (int i = 0; i < LANES; i++) sum[i] <= '0;
        count <= '0;
        least <= initial_min_dist;
      end
      if (cmd.finish && status.is_edge) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q[0] <= items.query_x;
      q[1] <= items.query_y;
      q[2] <= items.query_z;
      n[0] <= items.nbr_x;
      n[1] <= items.nbr_y;
      n[2] <= items.nbr_z;
      last <= items.last_neighbour;
    end
    if (cmd.diff) begin
      for (int i = 0; i < LANES; i++) mag[i] <= abs_diff(q[i], n[i]);
    end else if (cmd.cdiff) begin
      for (int i = 0; i < LANES; i++) mag[i] <= abs_diff(cent[i], q[i]);
    end
    if (cmd.square || cmd.csquare) begin
      for (int i = 0; i < LANES; i++) sq[i] <= SQ_W'(mag[i]) * SQ_W'(mag[i]);
    end
    if (cmd.csquare) begin
      prod_lo <= PROD_W'(edge_scale) * PROD_W'(least[HALF_W-1:0]);
      prod_hi <= PROD_W'(edge_scale) * PROD_W'(least[DIST_W-1:HALF_W]);
    end
    if (cmd.csum) begin
      dist_c <= sq_sum;
      bound  <= {prod_hi, HALF_W'(0)} + BOUND_W'(prod_lo);
    end
    if (cmd.finish && status.is_edge) begin
      for (int i = 0; i < LANES; i++) out_q[i] <= q[i];
    end
  end

endmodule

// File: hdl/knn_centroid_edge_point_test.sv
// Top level of the KNN centroid edge test: controller plus datapath.
// Depends on kce_pkg, the three channel interfaces, kce_ctrl and kce_datapath.
//
//   channel   role     beat carries
//   items     sink     query point, one neighbour, last_neighbour flag
//   results   source   edge point (query of a last neighbour judged an edge)
//   cfg       sink     reg_index, wdata (edge_scale, self_exclusion, initial_min_dist)
//
// A neighbour that is not last passes the diff, square and accumulate states before ready returns.
// A last neighbour then goes through the bit-serial centroid divider over SUM_W =
// 24 + clog2(MAX_NEIGHBOURS + 1) bits (30 at the default) and the compare states.
// Reset is synchronous and restores the register defaults and empty sums.
// A waiting edge point holds only the final compare; new neighbours are taken meanwhile
// until the next last neighbour judged an edge reaches that compare.
module knn_centroid_edge_point_test import kce_pkg::*; #(
  parameter int MAX_NEIGHBOURS = 32
) (
  input logic        clk,
  input logic        rst,
  kce_item_if.sink   items,
  kce_edge_if.source results,
  kce_cfg_if.sink    cfg
);

  kce_cmd_t    cmd;
  kce_status_t status;

  kce_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cmd    (cmd)
  );

  kce_datapath #(
    .MAX_NEIGHBOURS (MAX_NEIGHBOURS)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .status  (status),
    .items   (items),
    .results (results),
    .cfg     (cfg)
  );

endmodule

// File: hdl/kce_checker.sv
// Port-level checks for the KNN centroid edge test, bound to the top level.
// Depends on kce_pkg for the coordinate width.
module kce_checker import kce_pkg::*; (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic signed [COORD_W-1:0] out_x,
  input logic signed [COORD_W-1:0] out_y,
  input logic signed [COORD_W-1:0] out_z
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_x) && $stable(out_y) && $stable(out_z))
    else $error("result payload changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while the previous item is still in work");

  a_result_from_compare: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared without a completed edge test");

endmodule

bind knn_centroid_edge_point_test kce_checker u_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (items.valid),
  .in_ready  (items.ready),
  .out_valid (results.valid),
  .out_ready (results.ready),
  .out_x     (results.edge_x),
  .out_y     (results.edge_y),
  .out_z     (results.edge_z)
);

// File: verif/tb_knn_centroid_edge_point_test.sv
// Self-checking testbench for the KNN centroid edge test: a directed table, then random
// neighbour sets under four idle patterns, each beat checked against an in-bench predictor.
// Depends on kce_pkg, the three channel interfaces and knn_centroid_edge_point_test.
module tb_knn_centroid_edge_point_test;
  import kce_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_NBRS = 32;
  localparam int SETTLE_CYCLES = 64;
  localparam int CYCLE_LIMIT = 500000;
  localparam int PHASES = 8;
  localparam int PHASE_BEATS = 85;
  localparam int MAXC = 8388607;
  localparam int MINC = -8388608;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam logic [CFG_DAT_W-1:0] DIST_MAX = '1;
  localparam logic [CFG_DAT_W-1:0] EXCL_MAX = (1 << EXCL_W) - 1;
  localparam logic [CFG_DAT_W-1:0] SCALE_MAX = (1 << SCALE_W) - 1;

  typedef enum { NO_CHECK, NO_EDGE, IS_EDGE } row_check_t;

  typedef struct {
    logic signed [COORD_W-1:0] qx, qy, qz, nx, ny, nz;
    logic                      last;
  } nbr_beat_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x, y, z;
  } edge_point_t;

  typedef struct {
    int                   qx, qy, qz, nx, ny, nz;
    bit                   last;
    int                   reps;
    bit                   wr;
    logic [CFG_IDX_W-1:0] wr_idx;
    logic [CFG_DAT_W-1:0] wr_data;
    row_check_t           check;
  } dir_row_t;

  dir_row_t dir_rows [0:24] = '{
    '{0, 0, 0, 0, 0, 0, 1'b1, 1, 1'b0, CFG_EDGE_SCALE, 0, NO_EDGE},
    '{MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, 1'b1, 1, 1'b0, CFG_EDGE_SCALE, 0, IS_EDGE},
    '{MINC, MINC, MINC, MINC, MINC, MINC, 1'b1, 1, 1'b0, CFG_EDGE_SCALE, 0, IS_EDGE},
    '{MINC, MAXC, 0, MAXC, MINC, 0, 1'b1, 1, 1'b0, CFG_EDGE_SCALE, 0, IS_EDGE},
    '{4096, 4096, 4096, 4128, 4101, 4096, 1'b0, 1, 1'b0, CFG_EDGE_SCALE, 0, NO_CHECK},
    '{4096, 4096, 4096, 4128, 4101, 4097, 1'b1, 1, 1'b0, CFG_EDGE_SCALE, 0, NO_EDGE},
    '{-5000, 300, 0, -4900, 300, 0, 1'b0, 1, 1'b0, CFG_EDGE_SCALE, 0, NO_CHECK},
    '{-5000, 300, 0, -4700, 300, 0, 1'b1, 1, 1'b0, CFG_EDGE_SCALE, 0, NO_EDGE},
    '{-5000, 300, 0, -4900, 300, 0, 1'b0, 1, 1'b0, CFG_EDGE_SCALE, 0, NO_CHECK},
    '{-5000, 300, 0, -4698, 300, 0, 1'b1, 1, 1'b0, CFG_EDGE_SCALE, 0, IS_EDGE},
    '{0, 2048, 0, -1, 0, 0, 1'b0, 1, 1'b0, CFG_EDGE_SCALE, 0, NO_CHECK},
    '{0, 2048, 0, -2, 0, 0, 1'b1, 1, 1'b0, CFG_EDGE_SCALE, 0, NO_CHECK},
    '{1000, 1000, 1000, 3000, 1000, 1000, 1'b0, 1, 1'b0, CFG_EDGE_SCALE, 0, NO_CHECK},
    '{-1000, 0, 0, 3000, 1000, 1000, 1'b1, 1, 1'b0, CFG_EDGE_SCALE, 0, NO_CHECK},
    '{0, 0, 0, MAXC, MAXC, MAXC, 1'b0, 36, 1'b0, CFG_EDGE_SCALE, 0, NO_CHECK},
    '{0, 0, 0, MINC, MINC, MINC, 1'b1, 1, 1'b0, CFG_EDGE_SCALE, 0, NO_CHECK},
    '{2000, 0, 0, 2500, 0, 0, 1'b0, 1, 1'b0, CFG_EDGE_SCALE, 0, NO_CHECK},
    '{2000, 0, 0, 2600, 0, 0, 1'b1, 1, 1'b1, CFG_EDGE_SCALE, 0, IS_EDGE},
    '{0, 0, -3000, 0, 0, -2000, 1'b0, 1, 1'b1, CFG_EDGE_SCALE, 4, NO_CHECK},
    '{0, 0, -3000, 0, 0, -4000, 1'b1, 1, 1'b1, CFG_INITIAL_MIN, 0, NO_EDGE},
    '{0, 0, -3000, 0, 0, -3000, 1'b1, 1, 1'b0, CFG_EDGE_SCALE, 0, IS_EDGE},
    '{1024, 1024, 1024, 1024, 1024, 1024, 1'b1, 1, 1'b1, CFG_UNUSED, DIST_MAX, IS_EDGE},
    '{5, 5, 5, 5, 5, 5, 1'b1, 1, 1'b1, CFG_INITIAL_MIN, DIST_MAX, IS_EDGE},
    '{MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, 1'b1, 1, 1'b1, CFG_EDGE_SCALE, SCALE_MAX, NO_EDGE},
    '{0, 0, 0, 1024, 0, 0, 1'b1, 1, 1'b1, CFG_SELF_EXCLUSION, EXCL_MAX, NO_CHECK}
  };

  logic clk;
  logic rst;

  kce_item_if items_ch ();
  kce_edge_if edges_ch ();
  kce_cfg_if  cfg_ch ();

  knn_centroid_edge_point_test #(.MAX_NEIGHBOURS(MAX_NBRS)) dut (
    .clk     (clk),
    .rst     (rst),
    .items   (items_ch),
    .results (edges_ch),
    .cfg     (cfg_ch)
  );

  logic [SCALE_W-1:0] scale_r;
  logic [EXCL_W-1:0]  excl_r;
  logic [DIST_W-1:0]  init_min_r;
  longint             sum_x, sum_y, sum_z;
  int                 kept;
  logic [DIST_W-1:0]  least_dist;
  edge_point_t        expected_edges [$];
  edge_point_t        got_point;

  int send_idle_pct;
  int recv_stall_pct;
  int cycle_count;
  int mismatches;
  int beats_sent;
  int directed_beats;
  int edge_beats_seen;
  int reg_writes;
  int queries_sent;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [DIST_W-1:0] sq_dist(input longint ax, input longint ay,
                                                 input longint az, input longint bx,
                                                 input longint by, input longint bz);
    longint          dx, dy, dz;
    longint unsigned s;
    dx = ax - bx;
    dy = ay - by;
    dz = az - bz;
    s = dx * dx + dy * dy + dz * dz;
    return DIST_W'(s);
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatches < 20) begin
      $display("MISMATCH cycle %0d: %s", cycle_count, msg);
    end
    mismatches++;
  endtask

  task automatic clear_sums();
    sum_x = 0;
    sum_y = 0;
    sum_z = 0;
    kept = 0;
    least_dist = init_min_r;
  endtask

  // Accumulates one neighbour beat and, on the last one, decides whether the query is an edge.
  task automatic classify_neighbour(input nbr_beat_t b);
    longint            qx, qy, qz, nx, ny, nz, cx, cy, cz;
    logic [DIST_W-1:0] d, dc;
    longint unsigned   bound;
    edge_point_t       pt;
    qx = longint'(b.qx);
    qy = longint'(b.qy);
    qz = longint'(b.qz);
    nx = longint'(b.nx);
    ny = longint'(b.ny);
    nz = longint'(b.nz);
    d = sq_dist(qx, qy, qz, nx, ny, nz);
    if (d > DIST_W'(excl_r) && kept < MAX_NBRS) begin
      sum_x += nx;
      sum_y += ny;
      sum_z += nz;
      kept++;
      if (d < least_dist) least_dist = d;
    end
    if (b.last) begin
      cx = 0;
      cy = 0;
      cz = 0;
      if (kept > 0) begin
        cx = sum_x / longint'(kept);
        cy = sum_y / longint'(kept);
        cz = sum_z / longint'(kept);
      end
      dc = sq_dist(cx, cy, cz, qx, qy, qz);
      bound = 64'(scale_r) * 64'(least_dist);
      if (64'(dc) > bound) begin
        pt = '{b.qx, b.qy, b.qz};
        expected_edges.insert(expected_edges.size(), pt);
      end
      clear_sums();
    end
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (rst) begin
      scale_r = EDGE_SCALE_RST;
      excl_r = SELF_EXCLUSION_RST;
      init_min_r = INITIAL_MIN_RST;
      clear_sums();
      expected_edges.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.reg_index)
          CFG_EDGE_SCALE:     scale_r = cfg_ch.wdata[SCALE_W-1:0];
          CFG_SELF_EXCLUSION: excl_r = cfg_ch.wdata[EXCL_W-1:0];
          CFG_INITIAL_MIN:    init_min_r = cfg_ch.wdata;
          default: ;
        endcase
      end
      if (items_ch.valid && items_ch.ready) begin
        classify_neighbour('{items_ch.query_x, items_ch.query_y, items_ch.query_z,
                             items_ch.nbr_x, items_ch.nbr_y, items_ch.nbr_z,
                             items_ch.last_neighbour});
      end
      if (edges_ch.valid && edges_ch.ready) begin
        edge_beats_seen++;
        if (expected_edges.size() == 0) begin
          report_mismatch("edge point beat with none predicted");
        end else begin
          got_point = expected_edges.pop_front();
          if (edges_ch.edge_x !== got_point.x)
            report_mismatch($sformatf("edge_x %0d, predicted %0d", edges_ch.edge_x, got_point.x));
          if (edges_ch.edge_y !== got_point.y)
            report_mismatch($sformatf("edge_y %0d, predicted %0d", edges_ch.edge_y, got_point.y));
          if (edges_ch.edge_z !== got_point.z)
            report_mismatch($sformatf("edge_z %0d, predicted %0d", edges_ch.edge_z, got_point.z));
        end
      end
    end
  end

  always @(negedge clk) begin
    edges_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("Timeout after %0d cycles", cycle_count);
    $display("Verification failed");
    $finish;
  end

  task automatic send_beat(input nbr_beat_t b);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      items_ch.valid = 1'b0;
      @(negedge clk);
    end
    items_ch.query_x = b.qx;
    items_ch.query_y = b.qy;
    items_ch.query_z = b.qz;
    items_ch.nbr_x = b.nx;
    items_ch.nbr_y = b.ny;
    items_ch.nbr_z = b.nz;
    items_ch.last_neighbour = b.last;
    items_ch.valid = 1'b1;
    do @(posedge clk); while (!items_ch.ready);
    beats_sent++;
    if (b.last) queries_sent++;
  endtask

  task automatic wait_all_edges_out();
    @(negedge clk);
    items_ch.valid = 1'b0;
    while (expected_edges.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
    @(negedge clk);
    cfg_ch.reg_index = idx;
    cfg_ch.wdata = data;
    cfg_ch.valid = 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    reg_writes++;
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  function automatic logic [CFG_DAT_W-1:0] pick_scale();
    case ($urandom_range(5))
      0:       return '0;
      1:       return SCALE_MAX;
      2:       return EDGE_SCALE_RST;
      default: return CFG_DAT_W'($urandom_range(1, 8));
    endcase
  endfunction

  function automatic logic [CFG_DAT_W-1:0] pick_excl();
    case ($urandom_range(4))
      0:       return '0;
      1:       return EXCL_MAX;
      2:       return SELF_EXCLUSION_RST;
      default: return CFG_DAT_W'($urandom_range(0, (1 << EXCL_W) - 1));
    endcase
  endfunction

  function automatic logic [CFG_DAT_W-1:0] pick_init_min();
    case ($urandom_range(4))
      0:       return '0;
      1:       return DIST_MAX;
      2:       return INITIAL_MIN_RST;
      default: return CFG_DAT_W'({$urandom(), $urandom()}) >> $urandom_range(0, 40);
    endcase
  endfunction

  task automatic configure_phase(input int p);
    wait_all_edges_out();
    if (p == 0) begin
      write_reg(CFG_EDGE_SCALE, EDGE_SCALE_RST);
      write_reg(CFG_SELF_EXCLUSION, '0);
      write_reg(CFG_INITIAL_MIN, INITIAL_MIN_RST);
    end else begin
      write_reg(CFG_EDGE_SCALE, pick_scale());
      write_reg(CFG_SELF_EXCLUSION, pick_excl());
      write_reg(CFG_INITIAL_MIN, pick_init_min());
    end
    case (p % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
      default: begin send_idle_pct = 12; recv_stall_pct = 12; end
    endcase
  endtask

  // Mostly a query with a clustered, often one-sided neighbour set; some beats are plain noise.
  task automatic send_random_query();
    nbr_beat_t                 b;
    int                        k, spread, sel;
    int                        bias [3];
    int                        off [3];
    logic signed [COORD_W-1:0] q [3];
    bit                        jitter;
    if ($urandom_range(99) < 8) begin
      k = $urandom_range(1, 3);
      repeat (k) begin
        b.qx = COORD_W'($urandom());
        b.qy = COORD_W'($urandom());
        b.qz = COORD_W'($urandom());
        b.nx = COORD_W'($urandom());
        b.ny = COORD_W'($urandom());
        b.nz = COORD_W'($urandom());
        b.last = 1'($urandom_range(1));
        send_beat(b);
      end
    end else begin
      k = ($urandom_range(19) == 0) ? $urandom_range(30, 40) : $urandom_range(1, 8);
      spread = 1 << $urandom_range(0, 14);
      jitter = ($urandom_range(9) == 0);
      foreach (q[i]) q[i] = COORD_W'($urandom());
      foreach (bias[i]) bias[i] = int'($urandom_range(4 * spread)) - 2 * spread;
      for (int n = 0; n < k; n++) begin
        sel = $urandom_range(9);
        foreach (off[i]) begin
          if (sel == 0) off[i] = 0;
          else if (sel == 1) off[i] = int'($urandom_range(80)) - 40;
          else off[i] = bias[i] + int'($urandom_range(2 * spread)) - spread;
        end
        if (jitter) q[0] = COORD_W'(q[0] + int'($urandom_range(64)) - 32);
        b.qx = q[0];
        b.qy = q[1];
        b.qz = q[2];
        b.nx = COORD_W'(q[0] + off[0]);
        b.ny = COORD_W'(q[1] + off[1]);
        b.nz = COORD_W'(q[2] + off[2]);
        b.last = (n == k - 1);
        send_beat(b);
      end
    end
  endtask

  initial begin
    nbr_beat_t b;
    int        seen_before, phase_start, got;
    clk = 1'b0;
    rst = 1'b1;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    items_ch.valid = 1'b0;
    items_ch.query_x = '0;
    items_ch.query_y = '0;
    items_ch.query_z = '0;
    items_ch.nbr_x = '0;
    items_ch.nbr_y = '0;
    items_ch.nbr_z = '0;
    items_ch.last_neighbour = 1'b0;
    edges_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.reg_index = CFG_EDGE_SCALE;
    cfg_ch.wdata = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (dir_rows[r]) begin
      if (dir_rows[r].wr) begin
        wait_all_edges_out();
        write_reg(dir_rows[r].wr_idx, dir_rows[r].wr_data);
      end
      if (dir_rows[r].check != NO_CHECK) wait_all_edges_out();
      seen_before = edge_beats_seen;
      b.qx = COORD_W'(dir_rows[r].qx);
      b.qy = COORD_W'(dir_rows[r].qy);
      b.qz = COORD_W'(dir_rows[r].qz);
      b.nx = COORD_W'(dir_rows[r].nx);
      b.ny = COORD_W'(dir_rows[r].ny);
      b.nz = COORD_W'(dir_rows[r].nz);
      for (int i = 0; i < dir_rows[r].reps; i++) begin
        b.last = dir_rows[r].last && (i == dir_rows[r].reps - 1);
        send_beat(b);
      end
      if (dir_rows[r].check != NO_CHECK) begin
        wait_all_edges_out();
        got = edge_beats_seen - seen_before;
        if (got != ((dir_rows[r].check == IS_EDGE) ? 1 : 0))
          report_mismatch($sformatf("directed row %0d gave %0d edge beats", r, got));
      end
    end
    directed_beats = beats_sent;

    for (int p = 0; p < PHASES; p++) begin
      configure_phase(p);
      phase_start = beats_sent;
      while (beats_sent - phase_start < PHASE_BEATS) begin
        if ($urandom_range(29) == 0) wait_all_edges_out();
        send_random_query();
      end
    end
    wait_all_edges_out();

    $display("Covered %0d neighbour beats (%0d directed) in %0d queries, %0d register writes,",
             beats_sent, directed_beats, queries_sent, reg_writes);
    $display("four idle patterns, and %0d edge points checked; %0d mismatches.",
             edge_beats_seen, mismatches);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
